@@ rtl/lfw_pkg.sv @@
// Package for the line folder / word wrapper.
// Holds the character codes, register map, sequencer states and helpers.
// No dependencies.
package lfw_pkg;

  // Default build values
  localparam int unsigned WORD_MAX_DEF = 32;
  localparam int unsigned TAB_STOP_DEF = 4;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_FOLD   = 1'b0;
  localparam logic [7:0]  FOLD_RESET = 8'd10;
  localparam logic [7:0]  FOLD_MIN   = 8'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_NL    = 5'b00010,
    S_FETCH = 5'b00100,
    S_CHAR  = 5'b01000,
    S_DELIM = 5'b10000
  } lfw_state_t;

  // Column add that saturates at 255.
  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

@@ rtl/line_fold_word_wrap.sv @@
// Top level of the greedy word-wrap line folder.
// Depends on lfw_pkg and lfw_ram.
//
// Characters enter one item at a time on the in_ stream; in_tlast marks end of input.
// A non-blank character is stored in the word buffer, unless it is full, and gives no output.
// A space, tab, newline or end of input flushes the stored word through the out_ stream,
// one character per item, with newlines inserted where the fold column requires, and
// then echoes the delimiter (end of input is not echoed). out_tlast marks the final
// item caused by one input item. The flush reads the word buffer through its single
// registered read port, so each word character passes through a fetch state and an emit
// state, while inserted newlines and the delimiter need no buffer read.
// in_tready is low while a flush or delimiter is being emitted. fold_column sits at
// byte address 0 of the cfg_ port, resets to 10, and values below 2 act as 2.
module line_fold_word_wrap
  import lfw_pkg::*;
#(
  parameter int unsigned WORD_MAX = WORD_MAX_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_in
  input  logic                  in_tlast,   // end_of_input
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] char_out
  output logic                  out_tlast,  // last_of_run
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned IDX_W = $clog2(WORD_MAX);
  localparam int unsigned LEN_W = $clog2(WORD_MAX + 1);
  localparam int unsigned GAP_W = $clog2(TAB_STOP + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_MAX);

  lfw_state_t       state_r, state_nxt;
  logic [7:0]       fold_r;
  logic [7:0]       column_r, column_nxt;
  logic [LEN_W-1:0] word_len_r, word_len_nxt;
  logic             in_word_r, in_word_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] on_line_r, on_line_nxt;
  logic             cut_r, cut_nxt;
  logic             moved_r, moved_nxt;
  logic             eoi_r, eoi_nxt;
  logic [7:0]       delim_r, delim_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             is_delim;
  logic             can_load;
  logic [7:0]       fold_eff;
  logic [7:0]       len_ext;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_rdata;
  logic             last_char;
  logic             cfg_wr;
  logic [GAP_W-1:0] gap_tab [256];

  // Distance from each column to the next tab stop, fixed at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_gap
    assign gap_tab[g] = GAP_W'(TAB_STOP - (g % TAB_STOP));
  end

  // Configuration port: always ready, one register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[CFG_ADDR_W-1] == REG_FOLD);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_FOLD) ? {24'd0, fold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r <= FOLD_RESET;
    end else if (cfg_wr) begin
      fold_r <= cfg_pwdata[7:0];
    end
  end

  // Handshake terms.
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign can_load  = !out_valid_r || out_tready;
  assign is_delim  = in_tlast || (in_tdata == CH_SPACE) || (in_tdata == CH_TAB)
                     || (in_tdata == CH_NL);
  assign fold_eff  = (fold_r < FOLD_MIN) ? FOLD_MIN : fold_r;
  assign len_ext   = 8'(word_len_r);
  assign last_char = ({1'b0, idx_r} + 1'b1) == (IDX_W + 1)'(word_len_r);

  // Word buffer writes while characters of a word arrive.
  assign ram_waddr = in_word_r ? word_len_r[IDX_W-1:0] : '0;
  assign ram_we    = in_acc && !is_delim && (!in_word_r || (word_len_r < LEN_MAX));

  lfw_ram #(
    .WIDTH (8),
    .DEPTH (WORD_MAX)
  ) u_word_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Sequencer: stores words, then walks the buffer one character at a time.
  always_comb begin
    state_nxt     = state_r;
    column_nxt    = column_r;
    word_len_nxt  = word_len_r;
    in_word_nxt   = in_word_r;
    idx_nxt       = idx_r;
    on_line_nxt   = on_line_r;
    cut_nxt       = cut_r;
    moved_nxt     = moved_r;
    eoi_nxt       = eoi_r;
    delim_nxt     = delim_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_delim) begin
            // Word character: store it unless the buffer is full.
            if (ram_we) begin
              word_len_nxt = in_word_r ? word_len_r + 1'b1 : LEN_W'(1);
              column_nxt   = sat_add8(column_r, 8'd1);
            end
            in_word_nxt = 1'b1;
          end else begin
            eoi_nxt   = in_tlast;
            delim_nxt = in_tdata;
            if (in_word_r) begin
              // Decide how the pending word is placed on the line.
              moved_nxt   = (column_r > fold_eff) && (len_ext <= fold_eff);
              cut_nxt     = len_ext > fold_eff;
              idx_nxt     = '0;
              on_line_nxt = '0;
              if (((column_r > fold_eff) && (len_ext <= fold_eff))
                  || ((len_ext > fold_eff) && (column_r > len_ext))) begin
                state_nxt = S_NL;
              end else begin
                state_nxt = S_FETCH;
              end
            end else if (in_tlast) begin
              column_nxt = 8'd0;
            end else begin
              state_nxt = S_DELIM;
            end
          end
        end
      end

      S_NL: begin
        // Newline ahead of the word.
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = CH_NL;
          out_last_nxt  = 1'b0;
          state_nxt     = S_FETCH;
        end
      end

      S_FETCH: begin
        // Buffer read data is valid in the next cycle.
        state_nxt = S_CHAR;
      end

      S_CHAR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          if (cut_r && (8'(on_line_r) == fold_eff)) begin
            // A full piece stands on the line: break it.
            out_data_nxt = CH_NL;
            out_last_nxt = 1'b0;
            on_line_nxt  = '0;
          end else begin
            out_data_nxt = ram_rdata;
            out_last_nxt = last_char && eoi_r;
            on_line_nxt  = on_line_r + 1'b1;
            if (last_char) begin
              // Word done: settle the column and release the buffer.
              if (eoi_r) begin
                column_nxt = 8'd0;
              end else if (moved_r) begin
                column_nxt = len_ext;
              end else if (cut_r) begin
                column_nxt = 8'(on_line_r + 1'b1);
              end
              word_len_nxt = '0;
              in_word_nxt  = 1'b0;
              state_nxt    = eoi_r ? S_IDLE : S_DELIM;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_FETCH;
            end
          end
        end
      end

      S_DELIM: begin
        // Echo the delimiter and advance the column for it.
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = delim_r;
          out_last_nxt  = 1'b1;
          if (delim_r == CH_SPACE) begin
            column_nxt = sat_add8(column_r, 8'd1);
          end else if (delim_r == CH_TAB) begin
            column_nxt = sat_add8(column_r, 8'(gap_tab[column_r]));
          end else begin
            column_nxt = 8'd0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      column_r    <= 8'd0;
      word_len_r  <= '0;
      in_word_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      column_r    <= column_nxt;
      word_len_r  <= word_len_nxt;
      in_word_r   <= in_word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    on_line_r  <= on_line_nxt;
    cut_r      <= cut_nxt;
    moved_r    <= moved_nxt;
    eoi_r      <= eoi_nxt;
    delim_r    <= delim_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The stored word never grows past the buffer.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_len_r <= LEN_MAX)
    else $error("word length exceeds buffer size");

  // A word character produces no result and leaves the block ready.
  a_word_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_delim) |=> (state_r == S_IDLE))
    else $error("word character started output");

  // The flush only reads written buffer entries.
  a_read_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHAR) |-> ((IDX_W + 1)'(idx_r) < (IDX_W + 1)'(word_len_r)))
    else $error("buffer read beyond stored word");

endmodule

@@ rtl/lfw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the word buffer. No dependencies.
module lfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
